[src/cbr_pkg.sv]
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared sizes, register codes and fixed-point clamp helpers for the cubic
// root solver.
// ----------------------------------------------------------------------------
`default_nettype none
package cbr_pkg;

  localparam int FB    = 16;  // fraction bits

  localparam logic [15:0] TOL_RST   = 16'd1;
  localparam logic [7:0]  MAXIT_RST = 8'd100;

  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MAX_ITER  = 1'b1;

  localparam logic signed [31:0] DMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] DMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  function automatic logic ovf(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clampw(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = DMAX;
    end else if (v < -64'sd2147483648) begin
      r = DMIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/cbr_mul.sv]
// ----------------------------------------------------------------------------
// cbr_mul
// Shared signed multiplier: raw product and the floored, clamped Q product.
// ----------------------------------------------------------------------------
`default_nettype none
module cbr_mul (
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  output logic signed [63:0]      prod,
  output logic signed [31:0]      prod_q,
  output logic                    prod_sat
);

  logic signed [63:0] shifted;

  always_comb begin
    prod     = 64'(op_a) * 64'(op_b);
    // arithmetic shift floors toward minus infinity
    shifted  = prod >>> cbr_pkg::FB;
    prod_q   = cbr_pkg::clampw(shifted);
    prod_sat = cbr_pkg::ovf(shifted);
  end

endmodule
`default_nettype wire

[src/cbr_div.sv]
// ----------------------------------------------------------------------------
// cbr_div
// Restoring divider, one quotient bit per cycle: (num << FB) / den,
// truncated toward zero and clamped, with zero divisor handling.
// ----------------------------------------------------------------------------
`default_nettype none
module cbr_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [34:0]      num,
  input  wire logic signed [34:0]      den,
  output logic                         done,
  output logic signed [31:0]           quo,
  output logic                         sat
);

  logic                busy_r, fin_r, done_r;
  logic [5:0]          cnt_r;
  logic [49:0]         nq_r;
  logic [33:0]         rem_r, dv_r;
  logic                neg_r, sat_r;
  logic signed [31:0]  quo_r;

  logic [34:0] nmag, dmag, rem_sh;
  logic        ge, big;
  logic [31:0] qc;

  always_comb begin
    nmag   = num[34] ? 35'(-num) : 35'(num);
    dmag   = den[34] ? 35'(-den) : 35'(den);
    rem_sh = {rem_r, nq_r[49]};
    ge     = rem_sh >= {1'b0, dv_r};
    big    = (nq_r[49:32] != '0) || (nq_r[31] && (nq_r[30:0] != '0));
    qc     = big ? 32'h8000_0000 : nq_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= start ? (den == '0) : (!busy_r && fin_r);
      if (start) begin
        sat_r <= den == '0;
        if (den == '0) begin
          quo_r  <= (num > 0) ? cbr_pkg::DMAX : ((num < 0) ? cbr_pkg::DMIN : 32'sd0);
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 6'd49;
          nq_r   <= {nmag[33:0], 16'd0};
          dv_r   <= dmag[33:0];
          rem_r  <= '0;
          neg_r  <= num[34] != den[34];
        end
      end else if (busy_r) begin
        rem_r <= ge ? 34'(rem_sh - {1'b0, dv_r}) : rem_sh[33:0];
        nq_r  <= {nq_r[48:0], ge};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        if (neg_r) begin
          quo_r <= $signed(32'd0 - qc);
        end else if (qc[31]) begin
          quo_r <= cbr_pkg::DMAX;
          sat_r <= 1'b1;
        end else begin
          quo_r <= $signed(qc);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

endmodule
`default_nettype wire

[src/cbr_sqrt.sv]
// ----------------------------------------------------------------------------
// cbr_sqrt
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cbr_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic             done,
  output logic [31:0]      root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] v_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;

  logic [35:0] rem_sh, trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, v_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
        v_r    <= val;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
        root_r <= {root_r[30:0], ge};
        v_r    <= {v_r[61:0], 2'b00};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

[src/cubic_root_newton_solver.sv]
// ----------------------------------------------------------------------------
// cubic_root_newton_solver
// Finds one real root of a*x^3+b*x^2+c*x+d in signed Q16.16 by three Newton
// searches seeded from the stationary points.
// ----------------------------------------------------------------------------
// One item at a time: in_tready is high only while the sequencer is idle.
// Finding the stationary points takes two products, a square root and two
// divisions; each of the three searches then runs up to max_iter+1 Newton
// steps, each of seven products on the one shared multiplier and one
// division.
`default_nettype none
module cubic_root_newton_solver (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // coef_a, coef_b, coef_c, coef_d
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // root
  output logic              out_tuser,  // saturated
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [15:0]  cfg_data
);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_P   = 5'd1,  ST_M   = 5'd2,
                         ST_D    = 5'd3,  ST_SQ  = 5'd4,  ST_G0  = 5'd5,
                         ST_G0W  = 5'd6,  ST_G1  = 5'd7,  ST_G1W = 5'd8,
                         ST_INIT = 5'd9,  ST_F1  = 5'd10, ST_F2  = 5'd11,
                         ST_F3   = 5'd12, ST_F4  = 5'd13, ST_F5  = 5'd14,
                         ST_CHK  = 5'd15, ST_S1  = 5'd16, ST_S2  = 5'd17,
                         ST_NS   = 5'd18, ST_NW  = 5'd19, ST_SEL = 5'd20;

  logic [4:0]          state_r, state_nxt;
  logic [15:0]         tol_r;
  logic [7:0]          maxit_r;
  logic signed [31:0]  a_r, b_r, c_r, d_r;
  logic [63:0]         p_r, ac_r;
  logic [31:0]         s_r;
  logic signed [31:0]  g0_r, g1_r, x_r, x2_r, x3_r;
  logic signed [35:0]  acc_r, y_r, dy_r;
  logic [8:0]          n_r;
  logic [1:0]          ph_r;
  logic signed [31:0]  roots_r [3];
  logic                sat_r;
  logic                out_tvalid_r;
  logic [31:0]         out_root_r;
  logic                out_sat_r;
  logic                out_load;

  // shared units
  logic signed [31:0] ma, mb, mq;
  logic signed [63:0] mprod;
  logic               msat, mul_use;
  logic               div_start, div_done, div_sat;
  logic signed [34:0] div_num, div_den;
  logic signed [31:0] div_q;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic [63:0]        disc;

  cbr_mul u_mul (.op_a(ma), .op_b(mb), .prod(mprod), .prod_q(mq), .prod_sat(msat));

  cbr_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
                 .den(div_den), .done(div_done), .quo(div_q), .sat(div_sat));

  cbr_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sq_start), .val(disc),
                   .done(sq_done), .root(sq_root));

  // discriminant b^2 - 3ac, taken as a magnitude sum when the signs allow
  logic [65:0] m66, sum66;
  logic        add_case, sub_ok;
  logic signed [34:0] a35, b35;

  always_comb begin
    m66      = {2'b00, ac_r} + {1'b0, ac_r, 1'b0};
    sum66    = {2'b00, p_r} + m66;
    add_case = (a_r[31] != c_r[31]) || (a_r == '0) || (c_r == '0);
    sub_ok   = m66 <= {2'b00, p_r};
    if (add_case) begin
      disc = (sum66[65:64] != 2'b00) ? '1 : sum66[63:0];
    end else begin
      disc = 64'({2'b00, p_r} - m66);
    end
    sq_start = (state_r == ST_D) && (add_case || sub_ok);
    a35      = 35'(a_r);
    b35      = 35'(b_r);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_P:  begin ma = b_r;  mb = b_r;  end
      ST_M:  begin ma = a_r;  mb = c_r;  end
      ST_F1: begin ma = x_r;  mb = x_r;  end
      ST_F2: begin ma = x2_r; mb = x_r;  end
      ST_F3: begin ma = x3_r; mb = a_r;  end
      ST_F4: begin ma = x2_r; mb = b_r;  end
      ST_F5: begin ma = x_r;  mb = c_r;  end
      ST_S1: begin ma = x2_r; mb = a_r;  end
      ST_S2: begin ma = x_r;  mb = b_r;  end
      default: begin ma = '0; mb = '0; end
    endcase
    mul_use = state_r inside {ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_S1, ST_S2};
  end

  always_comb begin
    div_start = state_r inside {ST_G0, ST_G1, ST_NS};
    div_den   = a35 + (a35 <<< 1);
    if (state_r == ST_NS) begin
      div_num = y_r[34:0];
      div_den = dy_r[34:0];
    end else if (state_r == ST_G1) begin
      div_num = -b35 + $signed({3'b000, s_r});
    end else begin
      div_num = -b35 - $signed({3'b000, s_r});
    end
  end

  // sequencer
  logic signed [63:0] xs;
  logic signed [32:0] gsum;
  logic signed [35:0] mq36, ymag;
  logic               stop;
  logic               sat_nxt;
  logic signed [31:0] x_nxt;

  always_comb begin
    state_nxt = state_r;
    sat_nxt   = sat_r | (mul_use & msat);
    mq36      = 36'(mq);
    gsum      = 33'(g0_r) + 33'(g1_r);
    ymag      = y_r[35] ? -y_r : y_r;
    stop      = (ymag <= $signed({20'd0, tol_r})) || (n_r > {1'b0, maxit_r});
    xs        = '0;
    x_nxt     = x_r;
    case (ph_r)
      2'd0:    xs = 64'(g0_r) + 64'(cbr_pkg::ONE);
      2'd1:    xs = 64'(gsum >>> 1);
      default: xs = 64'(g1_r) - 64'(cbr_pkg::ONE);
    endcase
    if (state_r == ST_INIT) begin
      x_nxt   = cbr_pkg::clampw(xs);
      sat_nxt = sat_nxt | cbr_pkg::ovf(xs);
    end else if (state_r == ST_NW) begin
      xs = 64'(x_r) - 64'(div_q);
      if (div_done) begin
        x_nxt   = cbr_pkg::clampw(xs);
        sat_nxt = sat_nxt | div_sat | cbr_pkg::ovf(xs);
      end
    end else if ((state_r == ST_G0W || state_r == ST_G1W) && div_done) begin
      sat_nxt = sat_nxt | div_sat;
    end else if (state_r == ST_D && add_case && sum66[65:64] != 2'b00) begin
      sat_nxt = 1'b1;
    end else if (state_r == ST_IDLE) begin
      sat_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_P;
      ST_P:    state_nxt = ST_M;
      ST_M:    state_nxt = ST_D;
      ST_D:    state_nxt = (add_case || sub_ok) ? ST_SQ : ST_INIT;
      ST_SQ:   if (sq_done) state_nxt = ST_G0;
      ST_G0:   state_nxt = ST_G0W;
      ST_G0W:  if (div_done) state_nxt = ST_G1;
      ST_G1:   state_nxt = ST_G1W;
      ST_G1W:  if (div_done) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_F1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = ST_F3;
      ST_F3:   state_nxt = ST_F4;
      ST_F4:   state_nxt = ST_F5;
      ST_F5:   state_nxt = ST_CHK;
      ST_CHK: begin
        if (!stop) state_nxt = ST_S1;
        else if (ph_r == 2'd2) state_nxt = ST_SEL;
        else state_nxt = ST_INIT;
      end
      ST_S1:   state_nxt = ST_S2;
      ST_S2:   state_nxt = ST_NS;
      ST_NS:   state_nxt = ST_NW;
      ST_NW:   if (div_done) state_nxt = ST_F1;
      ST_SEL:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (state_r == ST_SEL) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tol_r        <= cbr_pkg::TOL_RST;
      maxit_r      <= cbr_pkg::MAXIT_RST;
      out_tvalid_r <= 1'b0;
      sat_r        <= 1'b0;
      ph_r         <= '0;
      n_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      sat_r        <= sat_nxt;
      x_r          <= x_nxt;
      out_tvalid_r <= out_load | (out_tvalid_r & ~out_tready);
      if (cfg_we) begin
        if (cfg_idx == cbr_pkg::CFG_TOLERANCE) tol_r <= cfg_data;
        else if (cfg_idx == cbr_pkg::CFG_MAX_ITER) maxit_r <= cfg_data[7:0];
      end
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          a_r   <= $signed(in_tdata[31:0]);
          b_r   <= $signed(in_tdata[63:32]);
          c_r   <= $signed(in_tdata[95:64]);
          d_r   <= $signed(in_tdata[127:96]);
          ph_r  <= '0;
          g0_r  <= '0;
          g1_r  <= '0;
        end
        ST_P:   p_r  <= mprod;
        ST_M:   ac_r <= mprod[63] ? 64'(-mprod) : mprod;
        ST_SQ:  if (sq_done) s_r <= sq_root;
        ST_G0W: if (div_done) g0_r <= div_q;
        ST_G1W: if (div_done) g1_r <= div_q;
        ST_INIT: n_r <= '0;
        ST_F1:  x2_r  <= mq;
        ST_F2:  x3_r  <= mq;
        ST_F3:  acc_r <= mq36;
        ST_F4:  acc_r <= acc_r + mq36;
        ST_F5:  y_r   <= acc_r + mq36 + 36'(d_r);
        ST_CHK: if (stop) begin
          roots_r[ph_r] <= x_r;
          ph_r          <= ph_r + 2'd1;
        end
        ST_S1:  acc_r <= mq36 + (mq36 <<< 1);
        ST_S2:  dy_r  <= acc_r + (mq36 <<< 1) + 36'(c_r);
        ST_NW:  if (div_done) n_r <= n_r + 9'd1;
        ST_SEL: if (out_load) begin
          out_sat_r    <= sat_r;
          if (!roots_r[0][31]) out_root_r <= roots_r[0];
          else if (!roots_r[1][31]) out_root_r <= roots_r[1];
          else out_root_r <= roots_r[2];
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_root_r;
  assign out_tuser  = out_sat_r;

endmodule
`default_nettype wire

[src/cbr_checker.sv]
// ----------------------------------------------------------------------------
// cbr_checker
// Port-level checks of the solver's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cbr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("solver ready right after input transfer");

  // a result never shows up the cycle after an input transfer
  a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");

  // a new result comes out of a busy block
  a_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result while idle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind cubic_root_newton_solver cbr_checker u_chk (.*);
`default_nettype wire

[tb/cubic_root_newton_solver_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_root_newton_solver_chk
// Watches the coefficient, root and register ports of the cubic root solver,
// computes the expected root and saturation flag of every accepted item and
// compares each root transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module cubic_root_newton_solver_chk (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [127:0] in_tdata,   // coef_a, coef_b, coef_c, coef_d
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [31:0]  out_tdata,  // root
  input  wire logic         out_tuser,  // saturated
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [15:0]  cfg_data,
  output int                errors,
  output int                pending,
  output int                roots_seen,
  output int                sat_seen
);

  typedef struct packed {
    logic [31:0] root;
    logic        saturated;
  } root_res_t;

  root_res_t   root_q[$];
  logic [15:0] tol;
  logic [7:0]  max_steps;
  bit          clip_hit;

  // model copy of the solver state
  longint      est_x, est_f, low_start, high_start;
  longint      roots[3];
  logic [7:0]  steps_done;
  logic [1:0]  phase;

  function automatic bit [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clip(longint v);
    if (v > cbr_pkg::DMAX) begin
      clip_hit = 1'b1;
      return cbr_pkg::DMAX;
    end
    if (v < cbr_pkg::DMIN) begin
      clip_hit = 1'b1;
      return cbr_pkg::DMIN;
    end
    return v;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return clip((x * y) >>> cbr_pkg::FB);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    bit [63:0] q;
    if (d == 0) begin
      clip_hit = 1'b1;
      return n > 0 ? longint'(cbr_pkg::DMAX) : (n < 0 ? longint'(cbr_pkg::DMIN) : 64'sd0);
    end
    q = (mag(n) << cbr_pkg::FB) / mag(d);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    if ((n < 0) != (d < 0)) return clip(-longint'(q));
    return clip(longint'(q));
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint poly_val(longint x, longint k[4]);
    longint x2, x3;
    x2 = qmul(x, x);
    x3 = qmul(x2, x);
    return qmul(x3, k[0]) + qmul(x2, k[1]) + qmul(x, k[2]) + k[3];
  endfunction

  function automatic longint poly_slope(longint x, longint k[4]);
    longint x2;
    x2 = qmul(x, x);
    return 3 * qmul(x2, k[0]) + 2 * qmul(x, k[1]) + k[2];
  endfunction

  function automatic longint newton_search(longint x, longint k[4]);
    longint y;
    int n;
    y = poly_val(x, k);
    n = 0;
    while (mag(y) > tol) begin
      x = clip(x - qdiv(y, poly_slope(x, k)));
      y = poly_val(x, k);
      n++;
      if (n > max_steps) break;
    end
    est_x = x;
    est_f = y;
    steps_done = 8'(n);
    return x;
  endfunction

  function automatic root_res_t solve_cubic(logic [127:0] coefs);
    longint k[4];
    longint g0, g1, s;
    bit [63:0] p, m, disc;
    root_res_t res;
    for (int i = 0; i < 4; i++) k[i] = longint'(signed'(coefs[32*i +: 32]));
    clip_hit = 1'b0;
    g0 = 0;
    g1 = 0;
    p = mag(k[1] * k[1]);
    m = 3 * mag(k[0] * k[2]);
    if ((k[0] < 0) != (k[2] < 0) || k[0] == 0 || k[2] == 0) begin
      if (m > ~64'd0 - p) begin
        clip_hit = 1'b1;
        disc = ~64'd0;
      end else begin
        disc = p + m;
      end
      s = longint'(int_sqrt(disc));
      g0 = qdiv(-k[1] - s, 3 * k[0]);
      g1 = qdiv(-k[1] + s, 3 * k[0]);
    end else if (m <= p) begin
      s = longint'(int_sqrt(p - m));
      g0 = qdiv(-k[1] - s, 3 * k[0]);
      g1 = qdiv(-k[1] + s, 3 * k[0]);
    end
    low_start = g0;
    high_start = g1;
    phase = 2'd0;
    roots[0] = newton_search(clip(g0 + cbr_pkg::ONE), k);
    phase = 2'd1;
    roots[1] = newton_search((g0 + g1) >>> 1, k);
    phase = 2'd2;
    roots[2] = newton_search(clip(g1 - cbr_pkg::ONE), k);
    if (roots[0] >= 0) res.root = roots[0][31:0];
    else if (roots[1] >= 0) res.root = roots[1][31:0];
    else res.root = roots[2][31:0];
    res.saturated = clip_hit;
    return res;
  endfunction

  always @(posedge clk) begin
    root_res_t exp_res;
    if (!rst_n) begin
      tol <= cbr_pkg::TOL_RST;
      max_steps <= cbr_pkg::MAXIT_RST;
      root_q.delete();
      errors = 0;
      roots_seen = 0;
      sat_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == cbr_pkg::CFG_TOLERANCE) tol <= cfg_data;
        else max_steps <= cfg_data[7:0];
      end
      if (in_tvalid && in_tready) root_q = {root_q, solve_cubic(in_tdata)};
      if (out_tvalid && out_tready) begin
        roots_seen++;
        if (out_tuser) sat_seen++;
        if (root_q.size() == 0) begin
          $error("root transfer with nothing expected: root=%h saturated=%b",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          exp_res = root_q.pop_front();
          if (out_tdata !== exp_res.root) begin
            $error("root: expected %h, got %h", exp_res.root, out_tdata);
            errors++;
          end
          if (out_tuser !== exp_res.saturated) begin
            $error("saturated: expected %b, got %b", exp_res.saturated, out_tuser);
            errors++;
          end
        end
      end
    end
    pending = root_q.size();
  end

endmodule

[tb/cubic_root_newton_solver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_root_newton_solver_tb
// Drives coefficient sets into the cubic root solver under several tolerance
// and iteration-limit settings, with random gaps on both sides and one long
// output stall; the checker predicts every root and flags mismatches.
// ----------------------------------------------------------------------------
module cubic_root_newton_solver_tb;

  localparam int IDLE_LIMIT = 400000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // coef_a, coef_b, coef_c, coef_d
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;  // root
  logic         out_tuser;  // saturated
  logic         cfg_we;
  logic         cfg_idx;
  logic [15:0]  cfg_data;
  int           errors, pending, roots_seen, sat_seen;
  int           coef_sets;
  bit           no_gaps;
  bit           long_hold;

  cubic_root_newton_solver dut (.*);
  cubic_root_newton_solver_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'(int'($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000);
      default: return 32'(int'($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000);
    endcase
  endfunction

  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 15);
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    coef_sets++;
  endtask

  // lower valid, let all roots come back, then a margin for the sequencer
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] tol, logic [7:0] steps);
    cfg_we <= 1'b1;
    cfg_idx <= cbr_pkg::CFG_TOLERANCE;
    cfg_data <= tol;
    @(posedge clk);
    cfg_idx <= cbr_pkg::CFG_MAX_ITER;
    cfg_data <= {8'd0, steps};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_sets(int n);
    for (int i = 0; i < n; i++) begin
      send_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  // receiver: random wait before each transfer, one long hold on request
  initial begin
    int w;
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold && !held) begin
        out_tready <= 1'b0;
        repeat (6000) @(posedge clk);
        held = 1'b1;
      end
      w = no_gaps ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = cbr_pkg::CFG_TOLERANCE;
    cfg_data = '0;
    coef_sets = 0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sets at reset settings
    send_coefs(32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0);        // x^3 - x
    send_coefs(32'h0001_0000, 32'hfffa_0000, 32'h000b_0000, 32'hfffa_0000);
    send_coefs(32'h0, 32'h0, 32'h0, 32'h0);                         // all zero
    send_coefs(32'h0, 32'h0001_0000, 32'h0, 32'hfffc_0000);        // a zero
    send_coefs(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000);        // linear
    send_coefs(32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0005_0000); // no stationary pt
    send_coefs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0); // negative disc
    send_coefs(cbr_pkg::DMIN, cbr_pkg::DMIN, cbr_pkg::DMAX, cbr_pkg::DMIN); // large disc, no overflow
    send_coefs(cbr_pkg::DMAX, cbr_pkg::DMAX, cbr_pkg::DMAX, cbr_pkg::DMAX);
    send_coefs(cbr_pkg::DMIN, cbr_pkg::DMIN, cbr_pkg::DMIN, cbr_pkg::DMIN);
    send_coefs(32'h0000_0001, cbr_pkg::DMAX, 32'hffff_ffff, 32'h0); // stationary point clamps
    send_coefs(32'hffff_ffff, 32'h0000_0001, 32'h0, 32'hffff_ffff);
    send_coefs(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    send_coefs(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_coefs(32'hffff_0000, 32'h0003_0000, 32'h0, 32'hfffe_0000);
    drain();

    // exact stop and an iteration limit of one, with the long output hold
    set_regs(16'd0, 8'd1);
    long_hold = 1'b1;
    random_sets(30);
    drain();

    // loosest tolerance, highest iteration limit: only three sets
    set_regs(16'hffff, 8'd255);
    random_sets(3);
    drain();

    // random settings, short searches
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(16'($urandom_range(0, 65535)), 8'($urandom_range(2, 10)));
      random_sets(10);
      drain();
    end

    // back-to-back, then gappy
    set_regs(16'd1, 8'd6);
    no_gaps = 1'b1;
    random_sets(15);
    no_gaps = 1'b0;
    random_sets(15);
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d coefficient sets over eight register settings", coef_sets);
    $display("checked %0d roots, %0d of them with saturation set", roots_seen, sat_seen);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[cubic_root_newton_solver.f]
src/cbr_pkg.sv
src/cbr_mul.sv
src/cbr_div.sv
src/cbr_sqrt.sv
src/cubic_root_newton_solver.sv
src/cbr_checker.sv
tb/cubic_root_newton_solver_chk.sv
tb/cubic_root_newton_solver_tb.sv
